>>> src/sfcp_pkg.sv
// Package for the sync framed command parser.
// Holds the shared constants and the result record type; depends on nothing.
package sfcp_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned ValueWidth    = 16;
   localparam int unsigned RunWidth      = 5;
   localparam int unsigned QueueDepthDef = 4;

   localparam logic [ByteWidth-1:0] SyncByte        = 8'hFF;
   localparam logic [RunWidth-1:0]  RunMax          = 5'd31;
   localparam logic [RunWidth-1:0]  SyncLengthReset = 5'd4;

   typedef struct packed {
      logic [ByteWidth-1:0]  cmd_id;
      logic [ValueWidth-1:0] cmd_value;
      logic [ByteWidth-1:0]  entry_index;
      logic                  last_in_frame;
      logic                  empty_frame;
   } result_type;

endpackage

>>> src/sfcp_front.sv
// Front end of the parser: sync hunt, frame count and command assembly.
// Classifies each accepted byte and emits a result record; uses sfcp_pkg.
`default_nettype none
module sfcp_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [sfcp_pkg::RunWidth-1:0] csr_sync_length,
   input  wire logic                          byte_valid,
   input  wire logic [sfcp_pkg::ByteWidth-1:0] rx_byte,
   output logic                               res_valid,
   output sfcp_pkg::result_type               res
);
   import sfcp_pkg::*;

   typedef enum logic [4:0] {
      ST_HUNT  = 5'b00001,
      ST_COUNT = 5'b00010,
      ST_ID    = 5'b00100,
      ST_LOW   = 5'b01000,
      ST_HIGH  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [RunWidth-1:0]   sync_len_ff, sync_len_in;
   logic [RunWidth-1:0]   ff_run_ff, ff_run_in;
   logic [ByteWidth-1:0]  remaining_ff, remaining_in;
   logic [ByteWidth-1:0]  entry_count_ff, entry_count_in;
   logic [ByteWidth-1:0]  held_id_ff, held_id_in;
   logic [ByteWidth-1:0]  held_low_ff, held_low_in;
   logic [RunWidth-1:0]   need;
   logic [RunWidth-1:0]   run_next;
   logic                  last_cmd;

   assign sync_len_in = csr_we ? csr_sync_length : sync_len_ff;
   assign need        = (sync_len_ff == '0) ? RunWidth'(1) : sync_len_ff;
   assign last_cmd    = (remaining_ff <= ByteWidth'(1));

   always_comb begin
      if (rx_byte == SyncByte) begin
         run_next = (ff_run_ff < RunMax) ? ff_run_ff + RunWidth'(1) : ff_run_ff;
      end else begin
         run_next = '0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      ff_run_in      = ff_run_ff;
      remaining_in   = remaining_ff;
      entry_count_in = entry_count_ff;
      held_id_in     = held_id_ff;
      held_low_in    = held_low_ff;
      res_valid      = 1'b0;
      res            = '0;
      if (byte_valid) begin
         unique case (state_ff)
            ST_HUNT: begin
               ff_run_in = run_next;
               if (run_next >= need) begin
                  state_in = ST_COUNT;
               end
            end
            ST_COUNT: begin
               if (rx_byte == '0) begin
                  res_valid       = 1'b1;
                  res.empty_frame = 1'b1;
                  state_in        = ST_HUNT;
                  ff_run_in       = '0;
                  remaining_in    = '0;
                  entry_count_in  = '0;
               end else begin
                  remaining_in   = rx_byte;
                  entry_count_in = '0;
                  state_in       = ST_ID;
               end
            end
            ST_ID: begin
               held_id_in = rx_byte;
               state_in   = ST_LOW;
            end
            ST_LOW: begin
               held_low_in = rx_byte;
               state_in    = ST_HIGH;
            end
            ST_HIGH: begin
               res_valid         = 1'b1;
               res.cmd_id        = held_id_ff;
               res.cmd_value     = {rx_byte, held_low_ff};
               res.entry_index   = entry_count_ff;
               res.last_in_frame = last_cmd;
               if (last_cmd) begin
                  state_in       = ST_HUNT;
                  ff_run_in      = '0;
                  remaining_in   = '0;
                  entry_count_in = '0;
               end else begin
                  remaining_in   = remaining_ff - ByteWidth'(1);
                  entry_count_in = entry_count_ff + ByteWidth'(1);
                  state_in       = ST_ID;
               end
            end
            default: begin
               state_in       = ST_HUNT;
               ff_run_in      = '0;
               remaining_in   = '0;
               entry_count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_HUNT;
         sync_len_ff    <= SyncLengthReset;
         ff_run_ff      <= '0;
         remaining_ff   <= '0;
         entry_count_ff <= '0;
         held_id_ff     <= '0;
         held_low_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         sync_len_ff    <= sync_len_in;
         ff_run_ff      <= ff_run_in;
         remaining_ff   <= remaining_in;
         entry_count_ff <= entry_count_in;
         held_id_ff     <= held_id_in;
         held_low_ff    <= held_low_in;
      end
   end

endmodule
`default_nettype wire

>>> src/sfcp_queue.sv
// Back end of the parser: a short result queue that presents the oldest item.
// Decouples the front end from the consumer; uses sfcp_pkg.
`default_nettype none
module sfcp_queue #(
   parameter int unsigned Depth = sfcp_pkg::QueueDepthDef
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire sfcp_pkg::result_type wr_data,
   input  wire logic                 rd_en,
   output sfcp_pkg::result_type      rd_data,
   output logic                      full,
   output logic                      empty
);
   import sfcp_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

   result_type            entries_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full    = (count_ff == CntWidth'(Depth));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = do_wr ? ((wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1))
                            : wr_ptr_ff;
   assign rd_ptr_in = do_rd ? ((rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1))
                            : rd_ptr_ff;

   always_comb begin
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + CntWidth'(1);
         2'b01:   count_in = count_ff - CntWidth'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> src/sync_framed_command_parser.sv
// Sync framed command parser: one received byte per cycle in, one item per completed
// command or empty frame out. The front-end state machine classifies each byte in the cycle
// it is accepted; a result reaches the queue at that edge and, if none is older, shows on
// rsp_ the next cycle. Bytes are taken every cycle while req_full is low; req_full rises
// only when QueueDepth results wait unread, so for QueueDepth > 1 a consumer that pops when
// rsp_empty is low never stalls the input. Depends on sfcp_pkg, sfcp_front and sfcp_queue.
`default_nettype none
module sync_framed_command_parser #(
   parameter int unsigned QueueDepth = sfcp_pkg::QueueDepthDef
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [sfcp_pkg::RunWidth-1:0]   csr_sync_length,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [sfcp_pkg::ByteWidth-1:0]  req_rx_byte,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [sfcp_pkg::ByteWidth-1:0]       rsp_cmd_id,
   output logic [sfcp_pkg::ValueWidth-1:0]      rsp_cmd_value,
   output logic [sfcp_pkg::ByteWidth-1:0]       rsp_entry_index,
   output logic                                 rsp_last_in_frame,
   output logic                                 rsp_empty_frame
);
   import sfcp_pkg::*;

   logic       accept;
   logic       res_valid;
   result_type res;
   result_type head;

   assign accept = req_push && !req_full;

   sfcp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_sync_length (csr_sync_length),
      .byte_valid      (accept),
      .rx_byte         (req_rx_byte),
      .res_valid       (res_valid),
      .res             (res)
   );

   sfcp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_valid),
      .wr_data (res),
      .rd_en   (rsp_pop),
      .rd_data (head),
      .full    (req_full),
      .empty   (rsp_empty)
   );

   assign rsp_cmd_id        = head.cmd_id;
   assign rsp_cmd_value     = head.cmd_value;
   assign rsp_entry_index   = head.entry_index;
   assign rsp_last_in_frame = head.last_in_frame;
   assign rsp_empty_frame   = head.empty_frame;

endmodule
`default_nettype wire

>>> src/sfcp_checker.sv
// Port-level checker for the sync framed command parser, with its bind.
// Watches only the top-level ports; uses sfcp_pkg for widths.
`default_nettype none
module sfcp_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_full,
   input  wire logic                            rsp_empty,
   input  wire logic                            rsp_pop,
   input  wire logic [sfcp_pkg::ByteWidth-1:0]  rsp_cmd_id,
   input  wire logic [sfcp_pkg::ValueWidth-1:0] rsp_cmd_value,
   input  wire logic [sfcp_pkg::ByteWidth-1:0]  rsp_entry_index,
   input  wire logic                            rsp_last_in_frame,
   input  wire logic                            rsp_empty_frame
);
   import sfcp_pkg::*;

   a_empty_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_empty_frame) |->
         (rsp_cmd_id == '0 && rsp_cmd_value == '0 && rsp_entry_index == '0 &&
          !rsp_last_in_frame))
      else $error("empty-frame item carries non-zero fields");

   a_reset_drains: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input stalled while no result waits");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_cmd_id) && $stable(rsp_cmd_value) &&
          $stable(rsp_entry_index) && $stable(rsp_last_in_frame) &&
          $stable(rsp_empty_frame)))
      else $error("waiting result changed without a pop");

endmodule

bind sync_framed_command_parser sfcp_checker u_sfcp_checker (.*);
`default_nettype wire
